>>> src/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants for the command frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

    // header bytes
    localparam logic [7:0] HDR_TORQUE = 8'h55;
    localparam logic [7:0] HDR_ANGLE  = 8'h56;

    // body length (counter + payload) per frame kind
    localparam logic [4:0] TORQUE_END = 5'd9;
    localparam logic [4:0] ANGLE_END  = 5'd17;
    localparam int         FRAME_BYTES = 17;

    // parser modes
    localparam logic [1:0] MODE_HUNT   = 2'd0;
    localparam logic [1:0] MODE_TORQUE = 2'd1;
    localparam logic [1:0] MODE_ANGLE  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_TORQUE = 2'd0;
    localparam logic [1:0] STATUS_ANGLE  = 2'd1;
    localparam logic [1:0] STATUS_BAD    = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  frame_count;
        logic [31:0] value_0;
        logic [31:0] value_1;
        logic [31:0] value_2;
        logic [31:0] value_3;
    } cfd_result_t;

    // parser to output stage
    typedef struct packed {
        logic        emit;
        cfd_result_t result;
    } cfd_parse_out_t;

endpackage

>>> src/command_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// command_frame_deframer_top
// A result is loaded into the result register when the parser steps on its checksum byte.
// Throughput: 1 byte per cycle; the input register drains into the parser
// each cycle, stalling only when a result meets a full result register.
// Reset: parser hunts for a header, previous byte and checksum are zero,
// no result pending.
// ----------------------------------------------------------------------------
module command_frame_deframer_top
    import cfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  frame_count,
    output logic [31:0] value_0,
    output logic [31:0] value_1,
    output logic [31:0] value_2,
    output logic [31:0] value_3
);

    logic           byte_valid_reg;
    logic [7:0]     byte_reg;
    logic           step;
    cfd_parse_out_t parse_out;
    cfd_result_t    result;

    // parser advances unless its result would hit a full result register
    assign step     = byte_valid_reg && (!parse_out.emit || !out_valid || out_ready);
    assign in_ready = !byte_valid_reg || step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            byte_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    cfd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_in   (byte_reg),
        .parse_out (parse_out)
    );

    cfd_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step && parse_out.emit),
        .result_in  (parse_out.result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result)
    );

    assign status      = result.status;
    assign frame_count = result.frame_count;
    assign value_0     = result.value_0;
    assign value_1     = result.value_1;
    assign value_2     = result.value_2;
    assign value_3     = result.value_3;

    // checks
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_TORQUE || status == STATUS_ANGLE ||
                       status == STATUS_BAD))
        else $error("unknown status code");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_BAD) |->
        (frame_count == 8'd0 && value_0 == 32'd0 && value_1 == 32'd0 &&
         value_2 == 32'd0 && value_3 == 32'd0))
        else $error("checksum error result carries data");

    a_torque_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_TORQUE) |->
        (value_0[31:16] == 16'd0 && value_1[31:16] == 16'd0 &&
         value_2[31:16] == 16'd0 && value_3[31:16] == 16'd0))
        else $error("torque result has upper bits set");

endmodule

>>> src/cfd_parse.sv
// ----------------------------------------------------------------------------
// cfd_parse
// Frame parser: header hunt, body capture, checksum and result assembly.
// ----------------------------------------------------------------------------
module cfd_parse
    import cfd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [7:0]     byte_in,
    output cfd_parse_out_t parse_out
);

    logic [1:0] mode_reg, mode_next;
    logic [4:0] pos_reg, pos_next;
    logic [7:0] prev_reg, prev_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] body_reg [FRAME_BYTES];

    logic       in_body;
    logic       at_end;
    logic [4:0] end_pos;

    assign in_body = (mode_reg == MODE_TORQUE) || (mode_reg == MODE_ANGLE);
    assign end_pos = (mode_reg == MODE_TORQUE) ? TORQUE_END : ANGLE_END;
    assign at_end  = in_body && (pos_reg >= end_pos);

    // next state for one byte
    always_comb
    begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        prev_next = prev_reg;
        sum_next  = sum_reg;
        if (in_body)
        begin
            if (at_end)
            begin
                // checksum byte: back to hunting, previous byte kept
                mode_next = MODE_HUNT;
                pos_next  = 5'd0;
            end
            else
            begin
                pos_next  = pos_reg + 5'd1;
                sum_next  = sum_reg + byte_in;
                prev_next = byte_in;
            end
        end
        else
        begin
            mode_next = MODE_HUNT;
            prev_next = byte_in;
            priority if (prev_reg == HDR_TORQUE && byte_in == HDR_TORQUE)
            begin
                mode_next = MODE_TORQUE;
                pos_next  = 5'd0;
                sum_next  = 8'd0;
            end
            else if (prev_reg == HDR_ANGLE && byte_in == HDR_ANGLE)
            begin
                mode_next = MODE_ANGLE;
                pos_next  = 5'd0;
                sum_next  = 8'd0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_HUNT;
            pos_reg  <= 5'd0;
            prev_reg <= 8'd0;
            sum_reg  <= 8'd0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            prev_reg <= prev_next;
            sum_reg  <= sum_next;
        end
    end

    // body byte store, one enable per entry
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            if (step && in_body && !at_end && pos_reg == 5'(i))
            begin
                body_reg[i] <= byte_in;
            end
        end
    end

    // result assembly from fixed store positions
    always_comb
    begin
        parse_out.emit   = at_end;
        parse_out.result = '0;
        if (byte_in != sum_reg)
        begin
            parse_out.result.status = STATUS_BAD;
        end
        else if (mode_reg == MODE_TORQUE)
        begin
            parse_out.result.status      = STATUS_TORQUE;
            parse_out.result.frame_count = body_reg[0];
            parse_out.result.value_0     = {16'd0, body_reg[1], body_reg[2]};
            parse_out.result.value_1     = {16'd0, body_reg[3], body_reg[4]};
            parse_out.result.value_2     = {16'd0, body_reg[5], body_reg[6]};
            parse_out.result.value_3     = {16'd0, body_reg[7], body_reg[8]};
        end
        else
        begin
            parse_out.result.status      = STATUS_ANGLE;
            parse_out.result.frame_count = body_reg[0];
            parse_out.result.value_0 = {body_reg[1], body_reg[2], body_reg[3], body_reg[4]};
            parse_out.result.value_1 = {body_reg[5], body_reg[6], body_reg[7], body_reg[8]};
            parse_out.result.value_2 = {body_reg[9], body_reg[10], body_reg[11],
                                        body_reg[12]};
            parse_out.result.value_3 = {body_reg[13], body_reg[14], body_reg[15],
                                        body_reg[16]};
        end
    end

endmodule

>>> src/cfd_out_reg.sv
// ----------------------------------------------------------------------------
// cfd_out_reg
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module cfd_out_reg
    import cfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  cfd_result_t result_in,
    output logic        out_valid,
    input  logic        out_ready,
    output cfd_result_t result_out
);

    logic        valid_reg;
    cfd_result_t data_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule
